[rtl/bdlp_pkg.sv]
// Shared types and constants for the button debounce / long press block.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package bdlp_pkg;

  // Configuration port
  localparam int CFG_DATA_W = 16;
  localparam int DBC_CFG_W  = 8;
  localparam int LPP_CFG_W  = 16;

  localparam logic CFG_IDX_DEBOUNCE = 1'b0;
  localparam logic CFG_IDX_LONG     = 1'b1;

  // Register reset values
  localparam logic [DBC_CFG_W-1:0] DBC_RESET = 8'd3;
  localparam logic [LPP_CFG_W-1:0] LPP_RESET = 16'd70;

  // Button codes
  localparam int          NUM_BUTTONS = 3;
  localparam logic [1:0]  BTN_UP      = 2'd0;
  localparam logic [1:0]  BTN_DOWN    = 2'd1;
  localparam logic [1:0]  BTN_CONFIRM = 2'd2;

  // Event kinds
  localparam logic KIND_PRESS = 1'b0;
  localparam logic KIND_LONG  = 1'b1;

  // Events raised by one tick, bit 0 first in delivery order
  typedef struct packed {
    logic cfm_long;
    logic cfm_press;
    logic down_press;
    logic up_press;
  } evt_mask_t;

  localparam logic [3:0] EVT_UP_PRESS   = 4'b0001;
  localparam logic [3:0] EVT_DOWN_PRESS = 4'b0010;
  localparam logic [3:0] EVT_CFM_PRESS  = 4'b0100;
  localparam logic [3:0] EVT_CFM_LONG   = 4'b1000;

  // Event queue status
  typedef struct packed {
    logic full;
    logic not_empty;
  } qstat_t;

endpackage

`default_nettype wire

[rtl/bdlp_if.sv]
// Handshake channels of the block: tick input and event output.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface bdlp_in_if;
  logic valid;
  logic ready;
  logic up_level;
  logic down_level;
  logic confirm_level;

  modport source (output valid, output up_level, output down_level,
                  output confirm_level, input ready);
  modport sink   (input valid, input up_level, input down_level,
                  input confirm_level, output ready);
endinterface

interface bdlp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] button_id;
  logic       event_kind;
  logic       last_event;

  modport source (output valid, output button_id, output event_kind,
                  output last_event, input ready);
  modport sink   (input valid, input button_id, input event_kind,
                  input last_event, output ready);
endinterface

`default_nettype wire

[rtl/bdlp_front.sv]
// Front end: config registers, per-button debounce state, event classification.
// Depends on bdlp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bdlp_front
  import bdlp_pkg::*;
#(
  parameter int DEBOUNCE_BITS = 8,
  parameter int HOLD_BITS     = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic                   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   tick_valid,
  output logic                        tick_ready,
  input  wire logic [NUM_BUTTONS-1:0] tick_levels,
  input  wire qstat_t                 q_stat,
  output logic                        push,
  output evt_mask_t                   push_data
);

  localparam int CW = (DEBOUNCE_BITS > DBC_CFG_W) ? DEBOUNCE_BITS : DBC_CFG_W;
  localparam int HW = (HOLD_BITS > LPP_CFG_W) ? HOLD_BITS : LPP_CFG_W;

  logic [DBC_CFG_W-1:0]     dbc_r;
  logic [LPP_CFG_W-1:0]     lpp_r;
  logic [NUM_BUTTONS-1:0]   prev_r, prev_nxt;
  logic [NUM_BUTTONS-1:0]   acc_r, acc_nxt;
  logic [DEBOUNCE_BITS-1:0] cnt_r [NUM_BUTTONS];
  logic [DEBOUNCE_BITS-1:0] cnt_nxt [NUM_BUTTONS];
  logic                     done_r, done_nxt;
  logic [HOLD_BITS-1:0]     held_r, held_nxt;

  logic [NUM_BUTTONS-1:0]   sample;
  logic [NUM_BUTTONS-1:0]   changed;
  logic                     tick_fire;
  evt_mask_t                evt;

  assign tick_ready = !q_stat.full;
  assign tick_fire  = tick_valid && tick_ready;

  always_comb begin
    sample   = ~tick_levels;
    prev_nxt = prev_r;
    acc_nxt  = acc_r;
    changed  = '0;
    evt      = '0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (sample[i] == prev_r[i]) begin
        // saturate at min(debounce count, counter max)
        if ((CW'(cnt_r[i]) < CW'(dbc_r)) && (cnt_r[i] != '1)) begin
          cnt_nxt[i] = cnt_r[i] + 1'b1;
        end else begin
          cnt_nxt[i] = cnt_r[i];
        end
      end else begin
        cnt_nxt[i]  = '0;
        prev_nxt[i] = sample[i];
      end
      if ((CW'(cnt_nxt[i]) >= CW'(dbc_r)) && (sample[i] != acc_r[i])) begin
        changed[i] = 1'b1;
        acc_nxt[i] = sample[i];
      end
    end

    evt.up_press   = changed[BTN_UP] && sample[BTN_UP];
    evt.down_press = changed[BTN_DOWN] && sample[BTN_DOWN];

    // hold counter runs on the level accepted before this tick
    held_nxt = held_r;
    if (acc_r[BTN_CONFIRM] && (held_r != '1)) begin
      held_nxt = held_r + 1'b1;
    end
    done_nxt = done_r;
    if (changed[BTN_CONFIRM]) begin
      if (sample[BTN_CONFIRM]) begin
        held_nxt = '0;
      end else begin
        evt.cfm_press = !done_r;
      end
      done_nxt = 1'b0;
    end

    if (acc_nxt[BTN_CONFIRM] && !done_nxt && (HW'(held_nxt) >= HW'(lpp_r))) begin
      evt.cfm_long = 1'b1;
      done_nxt     = 1'b1;
    end
  end

  assign push      = tick_fire && (evt != '0);
  assign push_data = evt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbc_r  <= DBC_RESET;
      lpp_r  <= LPP_RESET;
      prev_r <= '0;
      acc_r  <= '0;
      done_r <= 1'b0;
      held_r <= '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_IDX_DEBOUNCE: dbc_r <= cfg_data[DBC_CFG_W-1:0];
          CFG_IDX_LONG:     lpp_r <= cfg_data[LPP_CFG_W-1:0];
          default:          ;
        endcase
      end
      if (tick_fire) begin
        prev_r <= prev_nxt;
        acc_r  <= acc_nxt;
        done_r <= done_nxt;
        held_r <= held_nxt;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
          cnt_r[i] <= cnt_nxt[i];
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/bdlp_queue.sv]
// Two-entry queue of per-tick event masks between front and back end.
// Depends on bdlp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bdlp_queue
  import bdlp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire evt_mask_t push_data,
  input  wire logic      pop,
  output evt_mask_t      pop_data,
  output qstat_t         q_stat
);

  evt_mask_t  mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_pop;

  assign q_stat.full      = (cnt_r == 2'd2);
  assign q_stat.not_empty = (cnt_r != 2'd0);
  assign pop_data         = mem_r[rd_ptr_r];
  assign do_pop           = pop && q_stat.not_empty;

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

[rtl/bdlp_back.sv]
// Back end: holds one event mask and delivers its events one item per cycle while out_ready is high.
// Depends on bdlp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bdlp_back
  import bdlp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire qstat_t    q_stat,
  input  wire evt_mask_t q_data,
  output logic           pop,
  output logic           out_valid,
  input  wire logic      out_ready,
  output logic [1:0]     out_button_id,
  output logic           out_event_kind,
  output logic           out_last_event
);

  logic [3:0] mask_r, mask_nxt;
  logic [3:0] low_bit;
  logic [3:0] rest;
  logic       fire;
  logic       need_load;

  assign low_bit   = mask_r & (~mask_r + 4'd1);
  assign rest      = mask_r & ~low_bit;
  assign out_valid = (mask_r != 4'd0);
  assign fire      = out_valid && out_ready;
  assign need_load = !out_valid || (fire && (rest == 4'd0));
  assign pop       = need_load && q_stat.not_empty;

  always_comb begin
    out_button_id  = BTN_UP;
    out_event_kind = KIND_PRESS;
    unique case (low_bit)
      EVT_UP_PRESS:   out_button_id = BTN_UP;
      EVT_DOWN_PRESS: out_button_id = BTN_DOWN;
      EVT_CFM_PRESS:  out_button_id = BTN_CONFIRM;
      EVT_CFM_LONG: begin
        out_button_id  = BTN_CONFIRM;
        out_event_kind = KIND_LONG;
      end
      default: ;
    endcase
    out_last_event = (rest == 4'd0);
  end

  always_comb begin
    if (need_load) begin
      mask_nxt = q_stat.not_empty ? q_data : 4'd0;
    end else if (fire) begin
      mask_nxt = rest;
    end else begin
      mask_nxt = mask_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= 4'd0;
    end else begin
      mask_r <= mask_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/button_debounce_long_press.sv]
// Top level: debounce of three active-low buttons with confirm long press.
// Throughput: one tick per cycle while the queue has room; a tick's events
//   leave one per cycle while the consumer is ready (up to 3), so the event
//   serializer in the back end sets the sustained rate.
// Reset (sync, active low): all buttons released, registers at defaults.
// Depends on bdlp_pkg, bdlp_if, bdlp_front, bdlp_queue, bdlp_back.
`timescale 1ns / 1ps
`default_nettype none

module button_debounce_long_press
  import bdlp_pkg::*;
#(
  parameter int DEBOUNCE_BITS = 8,
  parameter int HOLD_BITS     = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  bdlp_in_if.sink                    in_ch,
  bdlp_out_if.source                 out_ch
);

  // Front -> queue: one mask per tick that raised at least one event.
  logic      push;
  evt_mask_t push_data;
  // Queue -> back
  logic      pop;
  evt_mask_t q_data;
  qstat_t    q_stat;

  // Front end: takes a tick whenever the queue has room. A tick with no
  // event only updates the debounce state and leaves nothing in the queue.
  bdlp_front #(
    .DEBOUNCE_BITS (DEBOUNCE_BITS),
    .HOLD_BITS     (HOLD_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .tick_valid  (in_ch.valid),
    .tick_ready  (in_ch.ready),
    .tick_levels ({in_ch.confirm_level, in_ch.down_level, in_ch.up_level}),
    .q_stat      (q_stat),
    .push        (push),
    .push_data   (push_data)
  );

  // Short queue decouples tick intake from event delivery, so a stalled
  // consumer does not stop the debounce logic until two masks are pending.
  bdlp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (q_data),
    .q_stat    (q_stat)
  );

  // Back end: the mask register doubles as the output register; events go
  // out lowest bit first (up, down, confirm press, confirm long press).
  bdlp_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_stat         (q_stat),
    .q_data         (q_data),
    .pop            (pop),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_button_id  (out_ch.button_id),
    .out_event_kind (out_ch.event_kind),
    .out_last_event (out_ch.last_event)
  );

  // Front never writes into a full queue.
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("event mask pushed into full queue");

  // A long press is always the final event of its tick.
  a_long_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.event_kind == KIND_LONG)) |-> out_ch.last_event)
    else $error("long press not marked as last event");

  // Nothing pending anywhere and nothing pushed: no event next cycle.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    (!q_stat.not_empty && !out_ch.valid && !push) |=> !out_ch.valid)
    else $error("event offered with nothing pending");

  // Queue content is only drained into the back end when it is free.
  a_pop_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && out_ch.valid) |-> (out_ch.ready && out_ch.last_event))
    else $error("queue popped while current mask still busy");

endmodule

`default_nettype wire
